// ===== rtl/fplw_pkg.sv =====
// Shared types, codes and field widths of the four-level page walker.
package fplw_pkg;

    // Field widths
    localparam int VA_W      = 48;
    localparam int ENTRY_W   = 64;
    localparam int ADDR_W    = 52;
    localparam int ROOT_W    = 36;
    localparam int LEVEL_W   = 2;
    localparam int PSIZE_W   = 2;
    localparam int INDEX_W   = 9;

    // Packed stream widths
    localparam int S_TDATA_W = 120;
    localparam int M_TDATA_W = 56;
    localparam int CFG_DW    = 64;
    localparam int CFG_AW    = 3;

    // Input action codes
    localparam logic ACT_TRANSLATE = 1'b0;
    localparam logic ACT_RESPONSE  = 1'b1;

    // Result kind codes
    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Walk levels: level of the entry read outstanding
    localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
    localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
    localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
    localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

    // Page size codes
    localparam logic [PSIZE_W-1:0] PS_4K = 2'd0;
    localparam logic [PSIZE_W-1:0] PS_2M = 2'd1;
    localparam logic [PSIZE_W-1:0] PS_1G = 2'd2;

    // Entry bit positions
    localparam int PRESENT_BIT   = 0;
    localparam int PAGE_SIZE_BIT = 7;

    // Input item
    typedef struct packed {
        logic               action;
        logic [VA_W-1:0]    vaddr;
        logic [ENTRY_W-1:0] read_data;
        logic               read_ok;
    } item_t;

    // Result item
    typedef struct packed {
        logic               out_kind;
        logic [ADDR_W-1:0]  out_address;
        logic               fault;
        logic [PSIZE_W-1:0] pg_size;
    } result_t;

    // Walker state
    typedef struct packed {
        logic               busy;
        logic [LEVEL_W-1:0] level;
        logic [VA_W-1:0]    va;
    } walk_state_t;

    // Step outcome: next state plus an optional result
    typedef struct packed {
        walk_state_t state;
        logic        emit;
        result_t     res;
    } step_t;

endpackage

// ===== rtl/fplw_step.sv =====
// Per-item walk step: decodes one request or entry response against the walker state.
module fplw_step (
    input  fplw_pkg::item_t                   item,
    input  fplw_pkg::walk_state_t             state,
    input  logic [fplw_pkg::ROOT_W-1:0]       root_table_frame,
    output fplw_pkg::step_t                   step
);

    // Table index of a level: PML4 bits 47..39 down to PT bits 20..12
    function automatic logic [fplw_pkg::INDEX_W-1:0] table_index(
        input logic [fplw_pkg::VA_W-1:0]    va,
        input logic [fplw_pkg::LEVEL_W-1:0] lvl
    );
        logic [fplw_pkg::INDEX_W-1:0] idx;
        case (lvl)
            fplw_pkg::LVL_PML4: idx = va[47:39];
            fplw_pkg::LVL_PDPT: idx = va[38:30];
            fplw_pkg::LVL_PD:   idx = va[29:21];
            default:            idx = va[20:12];
        endcase
        return idx;
    endfunction

    logic [fplw_pkg::ENTRY_W-1:0] entry;
    logic [fplw_pkg::VA_W-1:0]    va;
    logic [fplw_pkg::LEVEL_W-1:0] next_level;
    logic                         present;
    logic                         size_bit;

    assign entry      = item.read_data;
    assign va         = state.va;
    assign next_level = state.level + 2'd1;
    assign present    = item.read_ok && entry[fplw_pkg::PRESENT_BIT];
    assign size_bit   = entry[fplw_pkg::PAGE_SIZE_BIT];

    // Decide the next state and the result of this item
    always_comb begin
        step                 = '0;
        step.state           = state;
        step.emit            = 1'b0;
        step.res.out_kind    = fplw_pkg::KIND_READ;
        step.res.out_address = '0;
        step.res.fault       = 1'b0;
        step.res.pg_size     = fplw_pkg::PS_4K;

        if (item.action == fplw_pkg::ACT_TRANSLATE) begin
            // Start a walk at the PML4 entry; drop while busy
            if (!state.busy) begin
                step.state.busy      = 1'b1;
                step.state.level     = fplw_pkg::LVL_PML4;
                step.state.va        = item.vaddr;
                step.emit            = 1'b1;
                step.res.out_address = {4'd0, root_table_frame,
                                        table_index(item.vaddr,
                                                    fplw_pkg::LVL_PML4), 3'd0};
            end
        end else if (state.busy) begin
            step.emit = 1'b1;
            if (!present) begin
                // Failed read or non-present entry
                step.state.busy      = 1'b0;
                step.state.level     = fplw_pkg::LVL_PML4;
                step.res.out_kind    = fplw_pkg::KIND_DONE;
                step.res.fault       = 1'b1;
            end else if (state.level == fplw_pkg::LVL_PDPT && size_bit) begin
                // 1 GB page
                step.state.busy      = 1'b0;
                step.state.level     = fplw_pkg::LVL_PML4;
                step.res.out_kind    = fplw_pkg::KIND_DONE;
                step.res.out_address = {entry[51:30], va[29:0]};
                step.res.pg_size     = fplw_pkg::PS_1G;
            end else if (state.level == fplw_pkg::LVL_PD && size_bit) begin
                // 2 MB page
                step.state.busy      = 1'b0;
                step.state.level     = fplw_pkg::LVL_PML4;
                step.res.out_kind    = fplw_pkg::KIND_DONE;
                step.res.out_address = {entry[51:21], va[20:0]};
                step.res.pg_size     = fplw_pkg::PS_2M;
            end else if (state.level == fplw_pkg::LVL_PT) begin
                // 4 KB page
                step.state.busy      = 1'b0;
                step.state.level     = fplw_pkg::LVL_PML4;
                step.res.out_kind    = fplw_pkg::KIND_DONE;
                step.res.out_address = {entry[51:12], va[11:0]};
                step.res.pg_size     = fplw_pkg::PS_4K;
            end else begin
                // Descend one level and read the next entry
                step.state.level     = next_level;
                step.res.out_address = {entry[51:12], table_index(va, next_level), 3'd0};
            end
        end
    end

endmodule

// ===== rtl/four_level_page_walker.sv =====
// Top level of the four-level page walker: input stage, walk state, result register, APB port.
//
// Page walker for four-level 48-bit virtual addresses with 4 KB, 2 MB and 1 GB pages.
// Each input item (a translate request or an entry read response) is taken into an
// input register and decoded combinationally against the walk state into at most one
// result item, held in an output register: a new item is accepted every cycle while
// results are taken, and each result is registered in the output register after its
// input has passed the input register. The walk state of one item is updated before
// the next item is decoded, which sets that rate. A stalled result register holds the
// input stage, which holds s_tready low. The root table frame register answers at every
// byte address of the APB port and is used when a request starts a walk. Requests while
// a walk is in progress and responses while idle produce no result.
module four_level_page_walker (
    input  logic                               aclk,
    input  logic                               aresetn,

    // Input channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // tdata from bit 0: vaddr[47:0], read_data[63:0], read_ok, 7 zero bits
    input  logic [fplw_pkg::S_TDATA_W-1:0]     s_tdata,
    // tuser: action
    input  logic                               s_tuser,

    // Result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // tdata from bit 0: out_address[51:0], fault, pg_size[1:0], 1 zero bit
    output logic [fplw_pkg::M_TDATA_W-1:0]     m_tdata,
    // tuser: out_kind
    output logic                               m_tuser,

    // Configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fplw_pkg::CFG_AW-1:0]        paddr,
    input  logic [fplw_pkg::CFG_DW-1:0]        pwdata,
    output logic [fplw_pkg::CFG_DW-1:0]        prdata,
    output logic                               pready
);

    logic [fplw_pkg::ROOT_W-1:0] root_reg;
    logic                        in_valid_reg;
    fplw_pkg::item_t             in_item_reg;
    fplw_pkg::walk_state_t       state_reg;
    logic                        out_valid_reg;
    fplw_pkg::result_t           out_res_reg;

    fplw_pkg::item_t             s_item;
    fplw_pkg::step_t             step;
    logic                        out_free;
    logic                        proc;
    logic                        cfg_write;
    logic                        unused_cfg;

    // Configuration port: single register, byte offsets ignored
    assign pready     = 1'b1;
    assign cfg_write  = psel && penable && pwrite && pready;
    assign prdata     = {{(fplw_pkg::CFG_DW - fplw_pkg::ROOT_W){1'b0}}, root_reg};
    assign unused_cfg = ^{paddr, pwdata[fplw_pkg::CFG_DW-1:fplw_pkg::ROOT_W]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else if (cfg_write) begin
            root_reg <= pwdata[fplw_pkg::ROOT_W-1:0];
        end
    end

    // Unpack the input request
    assign s_item.action    = s_tuser;
    assign s_item.vaddr     = s_tdata[47:0];
    assign s_item.read_data = s_tdata[111:48];
    assign s_item.read_ok   = s_tdata[112];

    // Advance the input stage when the result register can take a result
    assign out_free = !out_valid_reg || m_tready;
    assign proc     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || proc;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= s_item;
        end
    end

    fplw_step u_step (
        .item             (in_item_reg),
        .state            (state_reg),
        .root_table_frame (root_reg),
        .step             (step)
    );

    // Walk state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (proc) begin
            state_reg <= step.state;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && step.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && step.emit) begin
            out_res_reg <= step.res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.out_kind;
    assign m_tdata  = {unused_cfg & 1'b0, out_res_reg.pg_size, out_res_reg.fault,
                       out_res_reg.out_address};

`ifndef ASSERT_OFF
    // A finished walk leaves the walker idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && step.emit && step.res.out_kind == fplw_pkg::KIND_DONE) |=> !state_reg.busy)
        else $error("walker still busy after a finished translation");

    // An entry read request leaves a walk in progress
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && step.emit && step.res.out_kind == fplw_pkg::KIND_READ) |=> state_reg.busy)
        else $error("walker idle after issuing an entry read");

    // A level past the top only exists during a walk
    a_level_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.level != fplw_pkg::LVL_PML4) |-> state_reg.busy)
        else $error("walk level set while idle");

    // No result is presented in the first cycle out of reset
    a_reset_quiet: assert property (@(posedge aclk)
        (aresetn && $past(!aresetn)) |-> !m_tvalid)
        else $error("result valid right after reset");
`endif

endmodule
